>>> src/cosb_pkg.sv
`default_nettype none
package cosb_pkg;

  localparam int MAX_VARIABLES_DEF = 64;
  localparam int MAX_COMPONENTS_DEF = 64;

  localparam int FUNC_W = 3;
  localparam int ID_W = 6;
  localparam int DIM_W = 16;
  localparam int CNT_W = 8;
  localparam int MULT_W = 2;
  localparam int DATA_W = 64;
  localparam int HALF_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam logic [MULT_W-1:0] MULT_MAX = '1;
  localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);
  localparam logic [DATA_W-1:0] SAT_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 3'd0,
    FUNC_ADD   = 3'd1,
    FUNC_DIM   = 3'd2,
    FUNC_BEGIN = 3'd3,
    FUNC_EVAL  = 3'd4
  } func_t;

  typedef struct packed {
    logic [DIM_W-1:0] dim;
    logic [CNT_W-1:0] work;
    logic [CNT_W-1:0] total;
  } var_entry_t;

  localparam int VAR_ENTRY_W = $bits(var_entry_t);

  typedef struct packed {
    logic done;
    logic ovf;
  } mul_status_t;

endpackage
`default_nettype wire

>>> src/cosb_if.sv
`default_nettype none
interface cosb_in_if import cosb_pkg::*; ();
  logic valid;
  logic ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0] component_id;
  logic [ID_W-1:0] variable_id;
  logic [DIM_W-1:0] dimension_value;

  modport source (output valid, output func, output component_id, output variable_id,
                  output dimension_value, input ready);
  modport sink (input valid, input func, input component_id, input variable_id,
                input dimension_value, output ready);
endinterface

interface cosb_out_if import cosb_pkg::*; ();
  logic valid;
  logic ready;
  logic [DATA_W-1:0] total_size;
  logic [DATA_W-1:0] level_width;
  logic saturated;

  modport source (output valid, output total_size, output level_width, output saturated,
                  input ready);
  modport sink (input valid, input total_size, input level_width, input saturated,
                output ready);
endinterface
`default_nettype wire

>>> src/cosb_ram.sv
`default_nettype none
module cosb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic re,
  input  wire logic [AW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> src/cosb_satmul.sv
`default_nettype none
module cosb_satmul import cosb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [DATA_W-1:0] a,
  input  wire logic [DIM_W-1:0] b,
  output logic [DATA_W-1:0] product,
  output mul_status_t status
);

  localparam int PART_W = HALF_W + DIM_W;

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_SUM} phase_t;

  phase_t phase;
  logic [DATA_W-1:0] a_q;
  logic [DIM_W-1:0] b_q;
  logic [PART_W-1:0] plo;
  logic [PART_W-1:0] phi;
  logic [HALF_W-1:0] mul_a;
  logic [PART_W-1:0] mul_out;
  logic [HALF_W:0] mid;
  logic ovf;

  // One 32x16 multiplier serves both halves of the 64-bit operand.
  assign mul_a = (phase == PH_LO) ? a_q[HALF_W-1:0] : a_q[DATA_W-1:HALF_W];
  assign mul_out = PART_W'(mul_a) * PART_W'(b_q);
  assign mid = (HALF_W+1)'(phi[HALF_W-1:0]) + (HALF_W+1)'(plo[PART_W-1:HALF_W]);
  assign ovf = (phi[PART_W-1:HALF_W] != '0) || mid[HALF_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      status <= '0;
    end else begin
      status.done <= 1'b0;
      case (phase)
        PH_IDLE: begin
          if (start) begin
            a_q <= a;
            b_q <= b;
            phase <= PH_LO;
          end
        end
        PH_LO: begin
          plo <= mul_out;
          phase <= PH_HI;
        end
        PH_HI: begin
          phi <= mul_out;
          phase <= PH_SUM;
        end
        PH_SUM: begin
          product <= ovf ? SAT_MAX : {mid[HALF_W-1:0], plo[HALF_W-1:0]};
          status.ovf <= ovf;
          status.done <= 1'b1;
          phase <= PH_IDLE;
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/component_ordering_size_bound.sv
`default_nettype none
// Size bound of a component ordering. Beats with func clear, add member and set dimension load
// the per-variable state counts and the component member lists; begin copies the occurrence
// totals into working counts and clears the context, the running size and the saturation flag;
// each evaluate beat takes the shared members of one component off the working counts and
// returns the saturating product of the context dimensions together with the running size.
// Every input beat gives exactly one result beat. The walk reads the variable entries one by one
// from the variable memory, and each context variable goes through the shared multiplier,
// which builds the 64-bit product from two 32x16 halves. The input is not ready while a beat
// is being worked on; one finished result may wait in the output register while the next beat
// is accepted.
module component_ordering_size_bound import cosb_pkg::*; #(
  parameter int MAX_VARIABLES = MAX_VARIABLES_DEF,
  parameter int MAX_COMPONENTS = MAX_COMPONENTS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  cosb_in_if.sink item,
  cosb_out_if.source result
);

  localparam int VAR_AW = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;
  localparam int COMP_AW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
  localparam int ROW_W = MAX_VARIABLES * MULT_W;
  localparam logic [VAR_AW-1:0] LAST_VAR = VAR_AW'(MAX_VARIABLES - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_ADD_WR, S_DIM_WR, S_COPY_RD, S_COPY_WR,
    S_EVAL_RD, S_EVAL_UPD, S_MUL_WAIT, S_SUM, S_FINISH
  } state_t;

  state_t state;
  logic [FUNC_W-1:0] func_q;
  logic [ID_W-1:0] comp_q;
  logic [ID_W-1:0] var_q;
  logic [DIM_W-1:0] dimv_q;
  logic [VAR_AW-1:0] idx;
  logic row_ok;
  logic [DATA_W-1:0] width;
  logic [DATA_W-1:0] total;
  logic flag;
  logic [MAX_VARIABLES-1:0] ctx;
  logic [MAX_VARIABLES-1:0] tot_valid;
  logic [MAX_VARIABLES-1:0] ent_valid;
  logic [MAX_COMPONENTS-1:0] row_valid;
  logic out_valid;
  logic [DATA_W-1:0] out_total;
  logic [DATA_W-1:0] out_width;
  logic out_sat;

  logic var_ok;
  logic comp_ok;
  logic [VAR_AW-1:0] var_a;
  logic [COMP_AW-1:0] comp_a;
  logic [VAR_AW-1:0] cur_a;

  logic var_we;
  logic var_re;
  logic [VAR_AW-1:0] var_raddr;
  var_entry_t var_wdata;
  var_entry_t var_rdata;
  logic row_we;
  logic row_re;
  logic [ROW_W-1:0] row_wdata;
  logic [ROW_W-1:0] row_rdata;

  logic [CNT_W-1:0] tot_eff;
  logic [CNT_W-1:0] work_eff;
  logic [DIM_W-1:0] dim_eff;
  logic [ROW_W-1:0] row_eff;
  logic [MULT_W-1:0] m;
  logic [MULT_W-1:0] m_inc;
  logic shared;
  logic [CNT_W-1:0] work_new;
  logic ctx_now;
  logic last;
  logic [DATA_W:0] sum;

  logic mul_start;
  logic [DATA_W-1:0] mul_product;
  mul_status_t mul_status;

  assign var_ok = int'(var_q) < MAX_VARIABLES;
  assign comp_ok = int'(comp_q) < MAX_COMPONENTS;
  assign var_a = VAR_AW'(var_q);
  assign comp_a = COMP_AW'(comp_q);
  assign cur_a = (state == S_ADD_WR || state == S_DIM_WR) ? var_a : idx;
  assign last = (idx == LAST_VAR);

  assign tot_eff = tot_valid[cur_a] ? var_rdata.total : '0;
  assign work_eff = ent_valid[cur_a] ? var_rdata.work : '0;
  assign dim_eff = ent_valid[cur_a] ? var_rdata.dim : DIM_ONE;
  assign row_eff = row_ok ? row_rdata : '0;
  assign m = row_eff[cur_a*MULT_W +: MULT_W];
  assign m_inc = (m == MULT_MAX) ? m : m + MULT_W'(1);
  assign shared = (m != '0) && (tot_eff > CNT_W'(1));
  assign work_new = (work_eff > CNT_W'(m)) ? work_eff - CNT_W'(m) : '0;
  assign ctx_now = shared ? (work_new != '0) : ctx[cur_a];
  assign sum = (DATA_W+1)'(total) + (DATA_W+1)'(width);

  assign mul_start = (state == S_EVAL_UPD) && ctx_now;

  always_comb begin
    var_re = 1'b0;
    var_raddr = idx;
    var_we = 1'b0;
    var_wdata = '{dim: dim_eff, work: work_eff, total: tot_eff};
    row_re = 1'b0;
    row_we = 1'b0;
    row_wdata = row_eff;
    case (state)
      S_DISPATCH: begin
        var_raddr = var_a;
        var_re = ((func_q == FUNC_ADD) && var_ok && comp_ok) ||
                 ((func_q == FUNC_DIM) && var_ok);
        row_re = ((func_q == FUNC_ADD) || (func_q == FUNC_EVAL)) && comp_ok;
      end
      S_ADD_WR: begin
        var_we = 1'b1;
        var_wdata.total = (tot_eff == CNT_MAX) ? tot_eff : tot_eff + CNT_W'(1);
        row_we = 1'b1;
        row_wdata[cur_a*MULT_W +: MULT_W] = m_inc;
      end
      S_DIM_WR: begin
        var_we = 1'b1;
        var_wdata.dim = dimv_q;
      end
      S_COPY_RD, S_EVAL_RD: begin
        var_re = 1'b1;
      end
      S_COPY_WR: begin
        var_we = 1'b1;
        var_wdata.work = tot_eff;
      end
      S_EVAL_UPD: begin
        var_we = shared;
        var_wdata.work = work_new;
      end
      default: begin
        var_re = 1'b0;
      end
    endcase
  end

  cosb_ram #(
    .WIDTH(VAR_ENTRY_W),
    .DEPTH(MAX_VARIABLES)
  ) u_var_ram (
    .clk(clk),
    .we(var_we),
    .waddr(cur_a),
    .wdata(var_wdata),
    .re(var_re),
    .raddr(var_raddr),
    .rdata(var_rdata)
  );

  cosb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(MAX_COMPONENTS)
  ) u_row_ram (
    .clk(clk),
    .we(row_we),
    .waddr(comp_a),
    .wdata(row_wdata),
    .re(row_re),
    .raddr(comp_a),
    .rdata(row_rdata)
  );

  cosb_satmul u_satmul (
    .clk(clk),
    .rst(rst),
    .start(mul_start),
    .a(width),
    .b(dim_eff),
    .product(mul_product),
    .status(mul_status)
  );

  assign item.ready = (state == S_IDLE);
  assign result.valid = out_valid;
  assign result.total_size = out_total;
  assign result.level_width = out_width;
  assign result.saturated = out_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      flag <= 1'b0;
      ctx <= '0;
      tot_valid <= '0;
      ent_valid <= '0;
      row_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      if (var_we) begin
        tot_valid[cur_a] <= 1'b1;
        ent_valid[cur_a] <= 1'b1;
      end
      if (row_we) begin
        row_valid[comp_a] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (item.valid) begin
            func_q <= item.func;
            comp_q <= item.component_id;
            var_q <= item.variable_id;
            dimv_q <= item.dimension_value;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          idx <= '0;
          row_ok <= comp_ok && row_valid[comp_a];
          state <= S_FINISH;
          case (func_q)
            FUNC_CLEAR: begin
              tot_valid <= '0;
              row_valid <= '0;
            end
            FUNC_ADD: begin
              if (var_ok && comp_ok) begin
                state <= S_ADD_WR;
              end
            end
            FUNC_DIM: begin
              if (var_ok) begin
                state <= S_DIM_WR;
              end
            end
            FUNC_BEGIN: begin
              ctx <= '0;
              total <= '0;
              flag <= 1'b0;
              state <= S_COPY_RD;
            end
            FUNC_EVAL: begin
              width <= DATA_W'(1);
              state <= S_EVAL_RD;
            end
            default: begin
              state <= S_FINISH;
            end
          endcase
        end
        S_ADD_WR, S_DIM_WR: begin
          state <= S_FINISH;
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (last) begin
            state <= S_FINISH;
          end else begin
            idx <= idx + VAR_AW'(1);
            state <= S_COPY_RD;
          end
        end
        S_EVAL_RD: begin
          state <= S_EVAL_UPD;
        end
        S_EVAL_UPD: begin
          if (shared) begin
            ctx[cur_a] <= (work_new != '0);
          end
          if (ctx_now) begin
            state <= S_MUL_WAIT;
          end else if (last) begin
            state <= S_SUM;
          end else begin
            idx <= idx + VAR_AW'(1);
            state <= S_EVAL_RD;
          end
        end
        S_MUL_WAIT: begin
          if (mul_status.done) begin
            width <= mul_product;
            flag <= flag | mul_status.ovf;
            if (last) begin
              state <= S_SUM;
            end else begin
              idx <= idx + VAR_AW'(1);
              state <= S_EVAL_RD;
            end
          end
        end
        S_SUM: begin
          if (sum[DATA_W]) begin
            total <= SAT_MAX;
            flag <= 1'b1;
          end else begin
            total <= sum[DATA_W-1:0];
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || result.ready) begin
            out_total <= total;
            out_width <= (func_q == FUNC_EVAL) ? width : '0;
            out_sat <= flag;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/cosb_checker.sv
`default_nettype none
module cosb_checker import cosb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic [FUNC_W-1:0] in_func,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [DATA_W-1:0] total_size,
  input wire logic [DATA_W-1:0] level_width,
  input wire logic saturated
);

  logic push;
  logic pop;
  logic [1:0] cnt;
  logic [FUNC_W-1:0] f0;
  logic [FUNC_W-1:0] f1;

  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  // Tracks the codes of beats whose results are still owed, oldest first.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      case ({push, pop})
        2'b10: begin
          if (cnt == 2'd0) begin
            f0 <= in_func;
          end else begin
            f1 <= in_func;
          end
          cnt <= cnt + 2'd1;
        end
        2'b01: begin
          f0 <= f1;
          cnt <= cnt - 2'd1;
        end
        2'b11: begin
          if (cnt == 2'd1) begin
            f0 <= in_func;
          end else begin
            f0 <= f1;
            f1 <= in_func;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    push |=> !in_ready)
    else $error("input ready one cycle after an accepted beat");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(total_size) &&
      $stable(level_width) && $stable(saturated))
    else $error("stalled result beat changed or dropped");

  a_result_owed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != 2'd0)
    else $error("result beat without an input beat");

  a_width_only_eval: assert property (@(posedge clk) disable iff (rst)
    out_valid && cnt != 2'd0 && f0 != FUNC_EVAL |-> level_width == '0)
    else $error("nonzero level width for a beat that is not an evaluation");

  a_begin_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && cnt != 2'd0 && f0 == FUNC_BEGIN |-> total_size == '0 && !saturated)
    else $error("begin beat did not clear the running size and flag");

endmodule

bind component_ordering_size_bound cosb_checker u_cosb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(item.valid),
  .in_ready(item.ready),
  .in_func(item.func),
  .out_valid(result.valid),
  .out_ready(result.ready),
  .total_size(result.total_size),
  .level_width(result.level_width),
  .saturated(result.saturated)
);
`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import cosb_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 11;
  localparam int ITEMS_WANTED = 1350;
  localparam int BULK_AFTER = 600;
  localparam int TAIL_BEATS = 150;
  localparam int HOLD_AFTER_BEATS = 400;
  localparam int HOLD_CYCLES = 800;
  localparam int DRAIN_CYCLES = 500;
  localparam int MAX_PRINTED = 40;
  localparam longint TIMEOUT_CYCLES = 3_000_000;
  localparam int NUM_VARS = MAX_VARIABLES_DEF;
  localparam int NUM_COMPS = MAX_COMPONENTS_DEF;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_FIRST = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_LAST = 3'd7;
  localparam logic [DIM_W-1:0] DIM_FULL = '1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0] comp;
    logic [ID_W-1:0] vid;
    logic [DIM_W-1:0] dim;
  } order_beat_t;

  typedef struct packed {
    logic [DATA_W-1:0] total;
    logic [DATA_W-1:0] width;
    logic sat;
  } size_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cosb_in_if in_bus();
  cosb_out_if out_bus();

  component_ordering_size_bound i_dut (
    .clk(clk),
    .rst(rst),
    .item(in_bus),
    .result(out_bus)
  );

  order_beat_t pending_q[$];
  size_result_t expected_q[$];

  order_beat_t cur_beat = '0;
  logic drv_valid = 1'b0;
  logic rx_ready = 1'b0;
  logic hold_rx = 1'b0;
  logic tail_phase = 1'b0;
  logic tx_calm = 1'b0;
  logic rx_calm = 1'b0;
  int idle_left = 0;
  int rx_stall = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int error_count = 0;
  int eval_count = 0;
  int sat_evals = 0;

  assign in_bus.valid = drv_valid;
  assign in_bus.func = cur_beat.func;
  assign in_bus.component_id = cur_beat.comp;
  assign in_bus.variable_id = cur_beat.vid;
  assign in_bus.dimension_value = cur_beat.dim;
  assign out_bus.ready = rx_ready;

  logic [CNT_W-1:0] occ_total [NUM_VARS];
  logic [CNT_W-1:0] work_count [NUM_VARS];
  logic [MULT_W-1:0] member_mult [NUM_COMPS][NUM_VARS];
  logic [DIM_W-1:0] var_dim [NUM_VARS];
  logic [NUM_VARS-1:0] in_context;
  logic [DATA_W-1:0] run_total;
  logic sat_flag;

  initial begin
    for (int v = 0; v < NUM_VARS; v++) begin
      occ_total[v] = '0;
      work_count[v] = '0;
      var_dim[v] = DIM_ONE;
      for (int c = 0; c < NUM_COMPS; c++) begin
        member_mult[c][v] = '0;
      end
    end
    in_context = '0;
    run_total = '0;
    sat_flag = 1'b0;
  end

  function automatic size_result_t predict_size(order_beat_t b);
    size_result_t r;
    logic [DATA_W-1:0] w;
    logic [2*DATA_W-1:0] prod;
    logic [DATA_W:0] sum;
    int c;
    int v;
    c = b.comp;
    v = b.vid;
    w = '0;
    case (b.func)
      FUNC_CLEAR: begin
        for (int i = 0; i < NUM_VARS; i++) begin
          occ_total[i] = '0;
          for (int j = 0; j < NUM_COMPS; j++) begin
            member_mult[j][i] = '0;
          end
        end
      end
      FUNC_ADD: begin
        if (member_mult[c][v] != MULT_MAX) begin
          member_mult[c][v] = member_mult[c][v] + MULT_W'(1);
        end
        if (occ_total[v] != CNT_MAX) begin
          occ_total[v] = occ_total[v] + CNT_W'(1);
        end
      end
      FUNC_DIM: begin
        var_dim[v] = b.dim;
      end
      FUNC_BEGIN: begin
        for (int i = 0; i < NUM_VARS; i++) begin
          work_count[i] = occ_total[i];
        end
        in_context = '0;
        run_total = '0;
        sat_flag = 1'b0;
      end
      FUNC_EVAL: begin
        for (int i = 0; i < NUM_VARS; i++) begin
          if (member_mult[c][i] != 0 && occ_total[i] > 1) begin
            if (work_count[i] > CNT_W'(member_mult[c][i])) begin
              work_count[i] = work_count[i] - CNT_W'(member_mult[c][i]);
            end else begin
              work_count[i] = '0;
            end
            in_context[i] = (work_count[i] != 0);
          end
        end
        w = DATA_W'(1);
        for (int i = 0; i < NUM_VARS; i++) begin
          if (in_context[i]) begin
            prod = (2*DATA_W)'(w) * (2*DATA_W)'(var_dim[i]);
            if (prod[2*DATA_W-1:DATA_W] != 0) begin
              w = SAT_MAX;
              sat_flag = 1'b1;
            end else begin
              w = prod[DATA_W-1:0];
            end
          end
        end
        sum = {1'b0, run_total} + {1'b0, w};
        if (sum[DATA_W]) begin
          run_total = SAT_MAX;
          sat_flag = 1'b1;
        end else begin
          run_total = sum[DATA_W-1:0];
        end
        eval_count++;
        if (sat_flag) begin
          sat_evals++;
        end
      end
      default: begin
      end
    endcase
    r.total = run_total;
    r.width = w;
    r.sat = sat_flag;
    return r;
  endfunction

  function automatic int rand_id();
    return $urandom_range(0, NUM_VARS - 1);
  endfunction

  task automatic queue_beat(logic [FUNC_W-1:0] f, int c, int v, int d);
    order_beat_t b;
    b.func = f;
    b.comp = ID_W'(c);
    b.vid = ID_W'(v);
    b.dim = DIM_W'(d);
    pending_q.insert(pending_q.size(), b);
  endtask

  task automatic queue_directed();
    queue_beat(FUNC_EVAL, 0, rand_id(), $urandom_range(0, 65535));
    for (int f = int'(FUNC_SPARE_FIRST); f <= int'(FUNC_SPARE_LAST); f++) begin
      queue_beat(FUNC_W'(f), rand_id(), rand_id(), $urandom_range(0, 65535));
    end
    queue_beat(FUNC_DIM, 0, NUM_VARS - 1, int'(DIM_FULL));
    queue_beat(FUNC_DIM, NUM_COMPS - 1, 0, 0);
    repeat (4) queue_beat(FUNC_ADD, NUM_COMPS - 1, NUM_VARS - 1, int'(DIM_FULL));
    queue_beat(FUNC_ADD, 0, NUM_VARS - 1, 0);
    queue_beat(FUNC_ADD, 0, 0, 0);
    queue_beat(FUNC_ADD, 1, 0, 0);
    queue_beat(FUNC_BEGIN, 0, 0, 0);
    queue_beat(FUNC_EVAL, NUM_COMPS - 1, 0, 0);
    queue_beat(FUNC_EVAL, 0, 0, 0);
    queue_beat(FUNC_EVAL, NUM_COMPS - 1, 0, 0);
    queue_beat(FUNC_EVAL, 1, 0, 0);
    queue_beat(FUNC_CLEAR, NUM_COMPS - 1, NUM_VARS - 1, int'(DIM_FULL));
    queue_beat(FUNC_EVAL, NUM_COMPS - 1, NUM_VARS - 1, int'(DIM_FULL));
    queue_beat(FUNC_BEGIN, NUM_COMPS - 1, NUM_VARS - 1, int'(DIM_FULL));
    queue_beat(FUNC_EVAL, NUM_COMPS - 1, 0, 0);
  endtask

  task automatic queue_episode();
    int pool[$];
    int comps[$];
    int nvar;
    int ncomp;
    int d;
    int c;
    logic wide;
    wide = ($urandom_range(0, 3) == 0);
    nvar = wide ? $urandom_range(6, 10) : $urandom_range(2, 8);
    ncomp = wide ? $urandom_range(3, 6) : $urandom_range(2, 8);
    repeat (nvar) pool.insert(pool.size(), rand_id());
    repeat (ncomp) comps.insert(comps.size(), $urandom_range(0, NUM_COMPS - 1));
    if ($urandom_range(0, 3) != 0) begin
      queue_beat(FUNC_CLEAR, rand_id(), rand_id(), $urandom_range(0, 65535));
    end
    foreach (pool[i]) begin
      case ($urandom_range(0, 11))
        0: d = 0;
        1, 2: d = int'(DIM_FULL);
        3, 4, 5, 6: d = $urandom_range(1, 4);
        default: d = $urandom_range(0, 65535);
      endcase
      if (wide) begin
        d = $urandom_range(40000, 65535);
      end
      queue_beat(FUNC_DIM, rand_id(), pool[i], d);
    end
    foreach (comps[i]) begin
      if (wide) begin
        foreach (pool[j]) queue_beat(FUNC_ADD, comps[i], pool[j], $urandom_range(0, 65535));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          queue_beat(FUNC_ADD, comps[i], pool[$urandom_range(0, nvar - 1)],
                     $urandom_range(0, 65535));
        end
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      queue_beat(FUNC_BEGIN, rand_id(), rand_id(), $urandom_range(0, 65535));
    end
    repeat (ncomp + $urandom_range(0, 2)) begin
      c = ($urandom_range(0, 5) == 0) ? $urandom_range(0, NUM_COMPS - 1)
                                        : comps[$urandom_range(0, ncomp - 1)];
      queue_beat(FUNC_EVAL, c, rand_id(), $urandom_range(0, 65535));
    end
  endtask

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      drv_valid <= 1'b0;
      idle_left <= 0;
    end else begin
      if (drv_valid && in_bus.ready) begin
        expected_q.insert(expected_q.size(), predict_size(cur_beat));
        beats_sent <= beats_sent + 1;
      end
      if (!drv_valid || in_bus.ready) begin
        if (idle_left != 0) begin
          idle_left <= idle_left - 1;
          drv_valid <= 1'b0;
        end else if (pending_q.size() == 0) begin
          drv_valid <= 1'b0;
        end else if (!tail_phase && !tx_calm && $urandom_range(0, 7) == 0) begin
          idle_left <= $urandom_range(0, 14);
          drv_valid <= 1'b0;
        end else begin
          cur_beat <= pending_q.pop_front();
          drv_valid <= 1'b1;
        end
      end
      if ($urandom_range(0, 99) == 0) begin
        tx_calm <= !tx_calm;
      end
      tail_phase <= (pending_q.size() < TAIL_BEATS);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rx_ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (hold_rx) begin
        rx_ready <= 1'b0;
      end else if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        rx_ready <= 1'b0;
      end else if (!tail_phase && !rx_calm && $urandom_range(0, 7) == 0) begin
        rx_stall <= $urandom_range(0, 14);
        rx_ready <= 1'b0;
      end else begin
        rx_ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) begin
        rx_calm <= !rx_calm;
      end
    end
  end

  always @(posedge clk) begin
    size_result_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (expected_q.size() == 0) begin
        report_error($sformatf("result beat with nothing expected: total_size %h",
                               out_bus.total_size));
      end else begin
        want = expected_q.pop_front();
        results_checked <= results_checked + 1;
        if (out_bus.total_size !== want.total) begin
          report_error($sformatf("total_size %h, expected %h", out_bus.total_size,
                                 want.total));
        end
        if (out_bus.level_width !== want.width) begin
          report_error($sformatf("level_width %h, expected %h", out_bus.level_width,
                                 want.width));
        end
        if (out_bus.saturated !== want.sat) begin
          report_error($sformatf("saturated %b, expected %b", out_bus.saturated, want.sat));
        end
      end
    end
  end

  // The receiver holds off long enough for the block to fill and stall its input.
  initial begin
    while (beats_sent < HOLD_AFTER_BEATS) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int stim_total;
    int noise;
    logic bulk_done;
    bulk_done = 1'b0;
    queue_directed();
    while (pending_q.size() < ITEMS_WANTED) begin
      if (!bulk_done && pending_q.size() > BULK_AFTER) begin
        // Every component holds one variable four times over, so its occurrence
        // total and the multiplicities reach their limits.
        bulk_done = 1'b1;
        noise = rand_id();
        queue_beat(FUNC_CLEAR, 0, 0, 0);
        queue_beat(FUNC_DIM, 0, noise, $urandom_range(2, 65535));
        for (int c = 0; c < NUM_COMPS; c++) begin
          repeat (4) queue_beat(FUNC_ADD, c, noise, $urandom_range(0, 65535));
        end
        queue_beat(FUNC_BEGIN, 0, 0, 0);
        repeat (10) queue_beat(FUNC_EVAL, $urandom_range(0, NUM_COMPS - 1), 0, 0);
      end else if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) begin
          queue_beat(FUNC_W'($urandom_range(0, int'(FUNC_SPARE_LAST))),
                     $urandom_range(0, NUM_COMPS - 1), rand_id(), $urandom_range(0, 65535));
        end
      end else begin
        queue_episode();
      end
    end
    stim_total = pending_q.size();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    while (beats_sent < stim_total) @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d input beats and checked %0d result beats.", beats_sent, results_checked);
    $display("Evaluated %0d components, %0d of them with the saturation flag set; %0d errors.",
             eval_count, sat_evals, error_count);
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
src/cosb_pkg.sv
src/cosb_if.sv
src/cosb_ram.sv
src/cosb_satmul.sv
src/component_ordering_size_bound.sv
src/cosb_checker.sv
tb/sv/testbench.sv
